// ===== rtl/i2cbm_pkg.sv =====
`default_nettype none

package i2cbm_pkg;

	localparam logic [2:0] FN_START = 3'd0;
	localparam logic [2:0] FN_STOP  = 3'd1;
	localparam logic [2:0] FN_WRITE = 3'd2;
	localparam logic [2:0] FN_READ  = 3'd3;
	localparam logic [2:0] FN_ACK   = 3'd4;
	localparam logic [2:0] FN_NACK  = 3'd5;
	localparam logic [2:0] FN_WAIT  = 3'd6;

	localparam logic REG_PHASE_CYCLES   = 1'b0;
	localparam logic REG_ACK_POLL_LIMIT = 1'b1;

	localparam logic [15:0] PHASE_CYCLES_RST   = 16'd1000;
	localparam logic [15:0] ACK_POLL_LIMIT_RST = 16'd256;

	typedef struct packed {
		logic        cmd_valid;
		logic [2:0]  func;
		logic [7:0]  tx_byte;
		logic        sda_in;
	} item_t;

	typedef struct packed {
		logic        scl_out;
		logic        sda_oe;
		logic        sda_out;
		logic        busy_res;
		logic        done_res;
		logic [7:0]  rx_byte;
		logic        ack_failed;
	} result_t;

	typedef struct packed {
		logic [15:0] phase_cycles;
		logic [15:0] ack_poll_limit;
	} cfg_t;

endpackage

`default_nettype wire

// ===== rtl/i2cbm_req_if.sv =====
`default_nettype none

interface i2cbm_req_if;
	logic        valid;
	logic        ready;
	logic        cmd_valid;
	logic [2:0]  func;
	logic [7:0]  tx_byte;
	logic        sda_in;

	modport source (output valid, cmd_valid, func, tx_byte, sda_in, input ready);
	modport sink (input valid, cmd_valid, func, tx_byte, sda_in, output ready);
endinterface

`default_nettype wire

// ===== rtl/i2cbm_rsp_if.sv =====
`default_nettype none

interface i2cbm_rsp_if;
	logic        valid;
	logic        ready;
	logic        scl_out;
	logic        sda_oe;
	logic        sda_out;
	logic        busy_res;
	logic        done_res;
	logic [7:0]  rx_byte;
	logic        ack_failed;

	modport source (output valid, scl_out, sda_oe, sda_out, busy_res, done_res, rx_byte,
		ack_failed, input ready);
	modport sink (input valid, scl_out, sda_oe, sda_out, busy_res, done_res, rx_byte,
		ack_failed, output ready);
endinterface

`default_nettype wire

// ===== rtl/i2cbm_seq.sv =====
`default_nettype none

module i2cbm_seq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire i2cbm_pkg::item_t  item,
	input  wire i2cbm_pkg::cfg_t   cfg,
	output i2cbm_pkg::result_t     result
);

	localparam logic [1:0] PH_0 = 2'd0;
	localparam logic [1:0] PH_1 = 2'd1;
	localparam logic [1:0] PH_2 = 2'd2;
	localparam logic [1:0] PH_3 = 2'd3;

	logic        active_q, active_d;
	logic [2:0]  cmd_q, cmd_d;
	logic [1:0]  ph_q, ph_d;
	logic [15:0] pc_q, pc_d;
	logic [3:0]  bc_q, bc_d;
	logic [7:0]  sr_q, sr_d;
	logic [15:0] poll_q, poll_d;
	logic        scl_q, scl_d;
	logic        oe_q, oe_d;
	logic        sda_q, sda_d;
	logic [7:0]  rx_q, rx_d;
	logic        ack_q, ack_d;
	logic        fin;
	logic        hold;
	logic        first;

	always_comb begin
		active_d = active_q;
		cmd_d    = cmd_q;
		ph_d     = ph_q;
		pc_d     = pc_q;
		bc_d     = bc_q;
		sr_d     = sr_q;
		poll_d   = poll_q;
		scl_d    = scl_q;
		oe_d     = oe_q;
		sda_d    = sda_q;
		rx_d     = rx_q;
		ack_d    = ack_q;
		fin      = 1'b0;
		hold     = 1'b0;

		// a new command is only taken while idle; func 7 is dropped
		if (!active_q && item.cmd_valid && item.func <= i2cbm_pkg::FN_WAIT) begin
			active_d = 1'b1;
			cmd_d    = item.func;
			ph_d     = PH_0;
			pc_d     = 16'd0;
			bc_d     = 4'd0;
			poll_d   = 16'd0;
			sr_d     = (item.func == i2cbm_pkg::FN_WRITE) ? item.tx_byte : 8'h00;
		end

		first = (pc_d == 16'd0);

		if (active_d) begin
			case (cmd_d)
				i2cbm_pkg::FN_START: begin
					if (ph_d >= PH_2) begin
						scl_d = 1'b0;
						fin   = 1'b1;
					end else if (first) begin
						if (ph_d == PH_0) begin
							oe_d  = 1'b1;
							sda_d = 1'b1;
							scl_d = 1'b1;
						end else begin
							sda_d = 1'b0;
						end
					end
				end
				i2cbm_pkg::FN_STOP: begin
					if (ph_d >= PH_2) begin
						fin = 1'b1;
					end else if (first) begin
						if (ph_d == PH_0) begin
							oe_d  = 1'b1;
							sda_d = 1'b0;
							scl_d = 1'b1;
						end else begin
							sda_d = 1'b1;
						end
					end
				end
				i2cbm_pkg::FN_ACK, i2cbm_pkg::FN_NACK: begin
					if (ph_d >= PH_2) begin
						scl_d = 1'b0;
						fin   = 1'b1;
					end else if (first) begin
						if (ph_d == PH_0) begin
							scl_d = 1'b0;
							oe_d  = 1'b1;
							sda_d = (cmd_d == i2cbm_pkg::FN_NACK);
						end else begin
							scl_d = 1'b1;
						end
					end
				end
				i2cbm_pkg::FN_WAIT: begin
					if (ph_d >= PH_2) begin
						// poll phase: no phase counting, one sample per cycle while step is high
						if (!item.sda_in) begin
							scl_d = 1'b0;
							ack_d = 1'b0;
							fin   = 1'b1;
						end else begin
							poll_d = poll_d + 16'd1;
							if (poll_d >= cfg.ack_poll_limit) begin
								ack_d = 1'b1;
								fin   = 1'b1;
							end
						end
						hold = !fin;
					end else if (first) begin
						if (ph_d == PH_0) begin
							sda_d = 1'b1;
						end else begin
							oe_d  = 1'b0;
							scl_d = 1'b1;
						end
					end
				end
				i2cbm_pkg::FN_WRITE: begin
					if (ph_d >= PH_3) begin
						fin = 1'b1;
					end else if (first) begin
						if (ph_d == PH_0) begin
							oe_d  = 1'b1;
							scl_d = 1'b0;
							sda_d = sr_d[7];
							sr_d  = {sr_d[6:0], 1'b0};
						end else if (ph_d == PH_1) begin
							scl_d = 1'b1;
						end else begin
							scl_d = 1'b0;
						end
					end
				end
				default: begin
					// read
					if (ph_d >= PH_3) begin
						rx_d = sr_d;
						fin  = 1'b1;
					end else if (first) begin
						if (ph_d == PH_0) begin
							oe_d  = 1'b0;
							scl_d = 1'b0;
						end else begin
							scl_d = 1'b1;
							sr_d  = {sr_d[6:0], item.sda_in};
						end
					end
				end
			endcase

			if (fin) begin
				active_d = 1'b0;
				pc_d     = 16'd0;
			end else if (!hold) begin
				pc_d = pc_d + 16'd1;
				if (pc_d >= cfg.phase_cycles) begin
					pc_d = 16'd0;
					if ((cmd_d == i2cbm_pkg::FN_WRITE && ph_d == PH_2) ||
					    (cmd_d == i2cbm_pkg::FN_READ && ph_d == PH_1)) begin
						bc_d = bc_d + 4'd1;
						ph_d = (bc_d < 4'd8) ? PH_0 : PH_3;
					end else begin
						ph_d = ph_d + 2'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cmd_q    <= i2cbm_pkg::FN_START;
			ph_q     <= PH_0;
			pc_q     <= 16'd0;
			bc_q     <= 4'd0;
			sr_q     <= 8'h00;
			poll_q   <= 16'd0;
			scl_q    <= 1'b1;
			oe_q     <= 1'b0;
			sda_q    <= 1'b1;
			rx_q     <= 8'h00;
			ack_q    <= 1'b0;
		end else if (step) begin
			active_q <= active_d;
			cmd_q    <= cmd_d;
			ph_q     <= ph_d;
			pc_q     <= pc_d;
			bc_q     <= bc_d;
			sr_q     <= sr_d;
			poll_q   <= poll_d;
			scl_q    <= scl_d;
			oe_q     <= oe_d;
			sda_q    <= sda_d;
			rx_q     <= rx_d;
			ack_q    <= ack_d;
		end
	end

	assign result.scl_out    = scl_d;
	assign result.sda_oe     = oe_d;
	assign result.sda_out    = sda_d;
	assign result.busy_res   = active_d;
	assign result.done_res   = fin;
	assign result.rx_byte    = rx_d;
	assign result.ack_failed = ack_d;

endmodule

`default_nettype wire

// ===== rtl/i2c_bit_level_master_core.sv =====
// I2C bit-level master. Every word on req is one clock tick of the bus
// sequencer: it carries the sampled SDA level and, optionally, a command
// (start, stop, write byte, read byte, ack, nack, wait for ack). Every word
// on rsp gives the pin levels, busy/done, the last read byte and the ack
// failure flag after that tick. Exactly one rsp word per req word, in order.
// A command is taken only while the sequencer is idle; others are ignored.
// Each bus phase lasts phase_cycles words (one if it is 0); wait-for-ack
// polls SDA once per word, up to ack_poll_limit times. A word accepted into
// the input register has its result registered in the output register.
// Throughput: one word per cycle while rsp is not stalled; the state update
// is a single registered pass of the sequencer logic. A stalled rsp holds
// its word while one more req word waits in the input register; req.ready
// drops only when both are full. Reset puts SCL high, SDA released, the
// sequencer idle, rx_byte and ack_failed to 0, phase_cycles to 1000 and
// ack_poll_limit to 256. Configuration is written through
// cfg_we/cfg_index/cfg_data; only while idle, which the user must ensure.
`default_nettype none

module i2c_bit_level_master_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data,
	i2cbm_req_if.sink        req,
	i2cbm_rsp_if.source      rsp
);

	i2cbm_pkg::cfg_t    cfg_q;
	i2cbm_pkg::item_t   item_s1;
	logic               valid_s1;
	i2cbm_pkg::result_t res_s2;
	logic               valid_s2;
	i2cbm_pkg::result_t res_next;
	logic               step;

	assign step      = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_cycles   <= i2cbm_pkg::PHASE_CYCLES_RST;
			cfg_q.ack_poll_limit <= i2cbm_pkg::ACK_POLL_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				i2cbm_pkg::REG_PHASE_CYCLES:   cfg_q.phase_cycles   <= cfg_data;
				i2cbm_pkg::REG_ACK_POLL_LIMIT: cfg_q.ack_poll_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready)
				valid_s1 <= req.valid;
			if (step)
				valid_s2 <= 1'b1;
			else if (rsp.ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.cmd_valid <= req.cmd_valid;
			item_s1.func      <= req.func;
			item_s1.tx_byte   <= req.tx_byte;
			item_s1.sda_in    <= req.sda_in;
		end
		if (step)
			res_s2 <= res_next;
	end

	i2cbm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (res_next)
	);

	assign rsp.valid      = valid_s2;
	assign rsp.scl_out    = res_s2.scl_out;
	assign rsp.sda_oe     = res_s2.sda_oe;
	assign rsp.sda_out    = res_s2.sda_out;
	assign rsp.busy_res   = res_s2.busy_res;
	assign rsp.done_res   = res_s2.done_res;
	assign rsp.rx_byte    = res_s2.rx_byte;
	assign rsp.ack_failed = res_s2.ack_failed;

endmodule

`default_nettype wire

// ===== sim/tb_i2c_bit_level_master_core.sv =====
`timescale 1ns / 100ps

module tb_i2c_bit_level_master_core;

	localparam logic [2:0] FN_NONE = 3'd7;
	localparam int unsigned NEVER_ACK = 32'hFFFF_FFFF;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 6;
	localparam int MAX_REPORTS = 100;
	localparam int WORD_TARGET = 900;
	localparam longint CYCLE_LIMIT = 200_000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [15:0] cfg_data;

	i2cbm_req_if req_ch();
	i2cbm_rsp_if rsp_ch();

	i2c_bit_level_master_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// bus master shadow: config, sequencer and pins
	logic [15:0] cfg_phase;
	logic [15:0] cfg_polls;
	logic seq_on;
	logic [2:0] seq_cmd;
	logic [1:0] seq_ph;
	logic [15:0] ph_cnt;
	logic [3:0] bit_cnt;
	logic [7:0] shift_q;
	logic [15:0] poll_cnt;
	logic pin_scl, pin_oe, pin_sda;
	logic [7:0] rx_hold;
	logic ack_fail;

	i2cbm_pkg::result_t pin_state_q[$];

	int errors = 0;
	int n_words = 0;
	int n_cmds = 0;
	int n_checked = 0;
	int n_timeouts = 0;
	longint cycles = 0;
	logic tx_jitter = 1'b0;
	logic rx_jitter = 1'b0;
	int hold_reqs = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[i2c_bit_level_master_core] ERROR");
			$finish;
		end
	end

	function automatic int stall_len();
		return ($urandom_range(0, 9) == 0) ? int'($urandom_range(15, 50)) :
			int'($urandom_range(1, 3));
	endfunction

	task automatic master_reset();
		cfg_phase = i2cbm_pkg::PHASE_CYCLES_RST;
		cfg_polls = i2cbm_pkg::ACK_POLL_LIMIT_RST;
		seq_on = 1'b0;
		seq_cmd = i2cbm_pkg::FN_START;
		seq_ph = 2'd0;
		ph_cnt = 16'd0;
		bit_cnt = 4'd0;
		shift_q = 8'h00;
		poll_cnt = 16'd0;
		pin_scl = 1'b1;
		pin_oe = 1'b0;
		pin_sda = 1'b1;
		rx_hold = 8'h00;
		ack_fail = 1'b0;
	endtask

	// one clock of the sequencer for an accepted word; queues the pin state it leaves
	task automatic bus_tick(input i2cbm_pkg::item_t w);
		logic fin;
		logic stay;
		logic first;
		i2cbm_pkg::result_t r;
		fin = 1'b0;
		stay = 1'b0;
		if (!seq_on && w.cmd_valid && w.func != FN_NONE) begin
			seq_on = 1'b1;
			seq_cmd = w.func;
			seq_ph = 2'd0;
			ph_cnt = 16'd0;
			bit_cnt = 4'd0;
			poll_cnt = 16'd0;
			shift_q = (w.func == i2cbm_pkg::FN_WRITE) ? w.tx_byte : 8'h00;
			n_cmds++;
		end
		if (seq_on) begin
			first = (ph_cnt == 16'd0);
			case (seq_cmd)
			i2cbm_pkg::FN_START: begin
				if (seq_ph >= 2'd2) begin
					pin_scl = 1'b0;
					fin = 1'b1;
				end else if (first) begin
					if (seq_ph == 2'd0) begin
						pin_oe = 1'b1;
						pin_sda = 1'b1;
						pin_scl = 1'b1;
					end else
						pin_sda = 1'b0;
				end
			end
			i2cbm_pkg::FN_STOP: begin
				if (seq_ph >= 2'd2)
					fin = 1'b1;
				else if (first) begin
					if (seq_ph == 2'd0) begin
						pin_oe = 1'b1;
						pin_sda = 1'b0;
						pin_scl = 1'b1;
					end else
						pin_sda = 1'b1;
				end
			end
			i2cbm_pkg::FN_ACK, i2cbm_pkg::FN_NACK: begin
				if (seq_ph >= 2'd2) begin
					pin_scl = 1'b0;
					fin = 1'b1;
				end else if (first) begin
					if (seq_ph == 2'd0) begin
						pin_scl = 1'b0;
						pin_oe = 1'b1;
						pin_sda = (seq_cmd == i2cbm_pkg::FN_NACK);
					end else
						pin_scl = 1'b1;
				end
			end
			i2cbm_pkg::FN_WAIT: begin
				if (seq_ph >= 2'd2) begin
					if (!w.sda_in) begin
						pin_scl = 1'b0;
						ack_fail = 1'b0;
						fin = 1'b1;
					end else begin
						poll_cnt = poll_cnt + 16'd1;
						if (poll_cnt >= cfg_polls) begin
							ack_fail = 1'b1;
							fin = 1'b1;
							n_timeouts++;
						end
					end
					// polling does not advance the phase timer
					stay = !fin;
				end else if (first) begin
					if (seq_ph == 2'd0)
						pin_sda = 1'b1;
					else begin
						pin_oe = 1'b0;
						pin_scl = 1'b1;
					end
				end
			end
			i2cbm_pkg::FN_WRITE: begin
				if (seq_ph >= 2'd3)
					fin = 1'b1;
				else if (first) begin
					if (seq_ph == 2'd0) begin
						pin_oe = 1'b1;
						pin_scl = 1'b0;
						pin_sda = shift_q[7];
						shift_q = {shift_q[6:0], 1'b0};
					end else if (seq_ph == 2'd1)
						pin_scl = 1'b1;
					else
						pin_scl = 1'b0;
				end
			end
			default: begin
				if (seq_ph >= 2'd3) begin
					rx_hold = shift_q;
					fin = 1'b1;
				end else if (first) begin
					if (seq_ph == 2'd0) begin
						pin_oe = 1'b0;
						pin_scl = 1'b0;
					end else begin
						// sample on the rising SCL edge
						pin_scl = 1'b1;
						shift_q = {shift_q[6:0], w.sda_in};
					end
				end
			end
			endcase
			if (fin) begin
				seq_on = 1'b0;
				ph_cnt = 16'd0;
			end else if (!stay) begin
				ph_cnt = ph_cnt + 16'd1;
				if (ph_cnt >= cfg_phase) begin
					ph_cnt = 16'd0;
					if ((seq_cmd == i2cbm_pkg::FN_WRITE && seq_ph == 2'd2) ||
					    (seq_cmd == i2cbm_pkg::FN_READ && seq_ph == 2'd1)) begin
						bit_cnt = bit_cnt + 4'd1;
						seq_ph = (bit_cnt < 4'd8) ? 2'd0 : 2'd3;
					end else
						seq_ph = seq_ph + 2'd1;
				end
			end
		end
		r.scl_out = pin_scl;
		r.sda_oe = pin_oe;
		r.sda_out = pin_sda;
		r.busy_res = seq_on;
		r.done_res = fin;
		r.rx_byte = rx_hold;
		r.ack_failed = ack_fail;
		pin_state_q.push_back(r);
	endtask

	// SDA as the slave would present it for the next word
	function automatic logic bus_sda(input logic [7:0] rd_pattern, input int unsigned ack_after);
		if (seq_on && seq_cmd == i2cbm_pkg::FN_READ && bit_cnt < 4'd8)
			return rd_pattern[3'd7 - bit_cnt[2:0]];
		if (seq_on && seq_cmd == i2cbm_pkg::FN_WAIT && seq_ph == 2'd2)
			return (poll_cnt < ack_after);
		return 1'($urandom);
	endfunction

	function automatic int unsigned pick_ack();
		if ($urandom_range(0, 4) == 0)
			return NEVER_ACK;
		return $urandom_range(0, (cfg_polls == 16'd0) ? 0 : int'(cfg_polls) - 1);
	endfunction

	task automatic send_word(input i2cbm_pkg::item_t w);
		int gap;
		gap = (tx_jitter && $urandom_range(0, 9) == 0) ? stall_len() : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd_valid <= w.cmd_valid;
		req_ch.func <= w.func;
		req_ch.tx_byte <= w.tx_byte;
		req_ch.sda_in <= w.sda_in;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		bus_tick(w);
		n_words++;
	endtask

	task automatic idle_word();
		i2cbm_pkg::item_t w;
		w.cmd_valid = 1'($urandom);
		w.func = w.cmd_valid ? FN_NONE : 3'($urandom);
		w.tx_byte = 8'($urandom);
		w.sda_in = 1'($urandom);
		send_word(w);
	endtask

	// issue a command from idle and clock it until done; stray commands ride along
	task automatic run_command(input logic [2:0] func, input logic [7:0] tx,
		input logic [7:0] rd_pattern, input int unsigned ack_after);
		i2cbm_pkg::item_t w;
		w.cmd_valid = 1'b1;
		w.func = func;
		w.tx_byte = tx;
		w.sda_in = bus_sda(rd_pattern, ack_after);
		send_word(w);
		while (seq_on) begin
			w.cmd_valid = ($urandom_range(0, 4) == 0);
			w.func = 3'($urandom);
			w.tx_byte = 8'($urandom);
			w.sda_in = bus_sda(rd_pattern, ack_after);
			send_word(w);
		end
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		while (pin_state_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == i2cbm_pkg::REG_PHASE_CYCLES)
			cfg_phase = val;
		else
			cfg_polls = val;
	endtask

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		i2cbm_pkg::result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pin_state_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: expected no result word, actual busy=%0b done=%0b",
						$time, rsp_ch.busy_res, rsp_ch.done_res);
			end else begin
				want = pin_state_q.pop_front();
				check_field("scl_out", 8'(want.scl_out), 8'(rsp_ch.scl_out));
				check_field("sda_oe", 8'(want.sda_oe), 8'(rsp_ch.sda_oe));
				check_field("sda_out", 8'(want.sda_out), 8'(rsp_ch.sda_out));
				check_field("busy_res", 8'(want.busy_res), 8'(rsp_ch.busy_res));
				check_field("done_res", 8'(want.done_res), 8'(rsp_ch.done_res));
				check_field("rx_byte", want.rx_byte, rsp_ch.rx_byte);
				check_field("ack_failed", 8'(want.ack_failed), 8'(rsp_ch.ack_failed));
				n_checked++;
			end
		end
	end

	// result side: random stalls, plus one long hold-off per request
	initial begin
		int holds_done;
		holds_done = 0;
		forever begin
			if (hold_reqs != holds_done) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
				rsp_ch.ready <= 1'b1;
				@(posedge clk);
			end else if (rx_jitter && $urandom_range(0, 7) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall_len()) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// reset pin levels, ignored words, and the reset poll limit
	task automatic test_reset_state();
		repeat (6) idle_word();
		write_reg(i2cbm_pkg::REG_PHASE_CYCLES, 16'd1);
		run_command(i2cbm_pkg::FN_WAIT, 8'h00, 8'h00, NEVER_ACK);
		idle_word();
	endtask

	task automatic test_directed();
		tx_jitter = 1'b1;
		rx_jitter = 1'b1;
		write_reg(i2cbm_pkg::REG_PHASE_CYCLES, 16'd1);
		write_reg(i2cbm_pkg::REG_ACK_POLL_LIMIT, 16'd3);
		run_command(i2cbm_pkg::FN_START, 8'h00, 8'h00, 0);
		run_command(i2cbm_pkg::FN_WRITE, 8'h00, 8'h00, 0);
		run_command(i2cbm_pkg::FN_WRITE, 8'hFF, 8'h00, 0);
		run_command(i2cbm_pkg::FN_WRITE, 8'hA5, 8'h00, 0);
		run_command(i2cbm_pkg::FN_WAIT, 8'h00, 8'h00, 0);
		run_command(i2cbm_pkg::FN_WAIT, 8'h00, 8'h00, 2);
		run_command(i2cbm_pkg::FN_WAIT, 8'h00, 8'h00, NEVER_ACK);
		run_command(i2cbm_pkg::FN_READ, 8'h00, 8'h00, 0);
		run_command(i2cbm_pkg::FN_READ, 8'h00, 8'hFF, 0);
		run_command(i2cbm_pkg::FN_READ, 8'h00, 8'h3C, 0);
		run_command(i2cbm_pkg::FN_ACK, 8'h00, 8'h00, 0);
		run_command(i2cbm_pkg::FN_NACK, 8'h00, 8'h00, 0);
		run_command(i2cbm_pkg::FN_STOP, 8'h00, 8'h00, 0);
		idle_word();
		// zero settings: one word per phase, fail on the first high poll
		write_reg(i2cbm_pkg::REG_PHASE_CYCLES, 16'd0);
		write_reg(i2cbm_pkg::REG_ACK_POLL_LIMIT, 16'd0);
		run_command(i2cbm_pkg::FN_START, 8'h00, 8'h00, 0);
		run_command(i2cbm_pkg::FN_WAIT, 8'h00, 8'h00, NEVER_ACK);
		run_command(i2cbm_pkg::FN_WAIT, 8'h00, 8'h00, 0);
		run_command(i2cbm_pkg::FN_WRITE, 8'h81, 8'h00, 0);
		run_command(i2cbm_pkg::FN_READ, 8'h00, 8'hC3, 0);
		run_command(i2cbm_pkg::FN_STOP, 8'h00, 8'h00, 0);
	endtask

	// largest poll limit, acked well before it runs out
	task automatic test_slow_extremes();
		tx_jitter = 1'b0;
		rx_jitter = 1'b0;
		write_reg(i2cbm_pkg::REG_PHASE_CYCLES, 16'd1);
		write_reg(i2cbm_pkg::REG_ACK_POLL_LIMIT, 16'hFFFF);
		run_command(i2cbm_pkg::FN_WAIT, 8'h00, 8'h00, 40);
	endtask

	// result side holds off long enough for the input side to back up
	task automatic test_backpressure();
		write_reg(i2cbm_pkg::REG_PHASE_CYCLES, 16'd2);
		write_reg(i2cbm_pkg::REG_ACK_POLL_LIMIT, 16'd5);
		hold_reqs++;
		run_command(i2cbm_pkg::FN_START, 8'h00, 8'h00, 0);
		run_command(i2cbm_pkg::FN_WRITE, 8'h6E, 8'h00, 0);
		run_command(i2cbm_pkg::FN_WAIT, 8'h00, 8'h00, 1);
		run_command(i2cbm_pkg::FN_READ, 8'h00, 8'h96, 0);
		run_command(i2cbm_pkg::FN_NACK, 8'h00, 8'h00, 0);
		run_command(i2cbm_pkg::FN_STOP, 8'h00, 8'h00, 0);
	endtask

	// start, address, ack, up to two data bytes, stop
	task automatic random_transaction();
		logic [7:0] addr;
		int n;
		addr = 8'($urandom);
		n = $urandom_range(0, 2);
		run_command(i2cbm_pkg::FN_START, 8'($urandom), 8'($urandom), 0);
		run_command(i2cbm_pkg::FN_WRITE, addr, 8'($urandom), 0);
		run_command(i2cbm_pkg::FN_WAIT, 8'($urandom), 8'($urandom), pick_ack());
		repeat (n) begin
			if (addr[0]) begin
				run_command(i2cbm_pkg::FN_READ, 8'($urandom), 8'($urandom), 0);
				run_command(($urandom_range(0, 3) == 0) ? i2cbm_pkg::FN_NACK :
					i2cbm_pkg::FN_ACK, 8'($urandom), 8'($urandom), 0);
			end else begin
				run_command(i2cbm_pkg::FN_WRITE, 8'($urandom), 8'($urandom), 0);
				run_command(i2cbm_pkg::FN_WAIT, 8'($urandom), 8'($urandom), pick_ack());
			end
		end
		run_command(i2cbm_pkg::FN_STOP, 8'($urandom), 8'($urandom), 0);
	endtask

	task automatic test_random();
		int s;
		logic [15:0] pc;
		logic [15:0] polls;
		s = 0;
		while (n_words < WORD_TARGET) begin
			if (s == 0)
				pc = 16'd0;
			else if ($urandom_range(0, 9) == 0)
				pc = 16'd3;
			else
				pc = 16'($urandom_range(1, 2));
			polls = ($urandom_range(0, 9) < 3) ? 16'($urandom_range(0, 2)) :
				16'($urandom_range(3, 10));
			write_reg(i2cbm_pkg::REG_PHASE_CYCLES, pc);
			write_reg(i2cbm_pkg::REG_ACK_POLL_LIMIT, polls);
			tx_jitter = (s % 3 != 2);
			rx_jitter = (s % 4 != 3);
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(0, 3)) idle_word();
				run_command(3'($urandom_range(0, 6)), 8'($urandom), 8'($urandom), pick_ack());
			end else
				random_transaction();
			s++;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= i2cbm_pkg::REG_PHASE_CYCLES;
		cfg_data <= 16'd0;
		req_ch.valid <= 1'b0;
		req_ch.cmd_valid <= 1'b0;
		req_ch.func <= i2cbm_pkg::FN_START;
		req_ch.tx_byte <= 8'h00;
		req_ch.sda_in <= 1'b1;
		master_reset();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_directed();
		test_slow_extremes();
		test_backpressure();
		test_random();
		settle();

		$display("Ran %0d bus commands in %0d words: reset values, directed, largest poll limit,",
			n_cmds, n_words);
		$display("long result stall and random transactions; %0d words checked, %0d ack timeouts.",
			n_checked, n_timeouts);
		if (errors == 0)
			$display("[i2c_bit_level_master_core] OK");
		else
			$display("[i2c_bit_level_master_core] ERROR");
		$finish;
	end

endmodule
